// ===== src/stf_pkg.sv =====
// Shared types, codes and helpers for the servo tape feeder sequencer.
// No dependencies; every other file of the block uses this package.
package stf_pkg;

  // Action codes of a request
  localparam logic [2:0] ACT_TICK      = 3'd0;
  localparam logic [2:0] ACT_ADVANCE   = 3'd1;
  localparam logic [2:0] ACT_POST_PICK = 3'd2;
  localparam logic [2:0] ACT_DISABLE   = 3'd3;
  localparam logic [2:0] ACT_GO_ANGLE  = 3'd4;

  // Servo positions
  localparam logic [1:0] POS_RETRACT = 2'd0;
  localparam logic [1:0] POS_HALF    = 2'd1;
  localparam logic [1:0] POS_FULL    = 2'd2;
  localparam logic [1:0] POS_NONE    = 2'd3;

  // Motion phases
  localparam logic [1:0] PH_MOVING    = 2'd0;
  localparam logic [1:0] PH_COMPLETED = 2'd1;
  localparam logic [1:0] PH_IDLE      = 2'd2;

  // Fault status codes
  localparam logic [1:0] FLT_NO_LINE = 2'd0;
  localparam logic [1:0] FLT_OK      = 2'd1;
  localparam logic [1:0] FLT_IGNORED = 2'd2;
  localparam logic [1:0] FLT_ERROR   = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_FULL_ANGLE    = 3'd0;
  localparam logic [2:0] REG_HALF_ANGLE    = 3'd1;
  localparam logic [2:0] REG_RETRACT_ANGLE = 3'd2;
  localparam logic [2:0] REG_SETTLE_MS     = 3'd3;
  localparam logic [2:0] REG_IGNORE_SW_ERR = 3'd4;
  localparam logic [2:0] REG_HAS_SWITCH    = 3'd5;
  localparam logic [2:0] REG_UNIT_LENGTH   = 3'd6;

  localparam int CFG_DATA_W = 16;
  localparam logic [15:0] SETTLE_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] request_length;
    logic       override_fault;
    logic       switch_open;
    logic [7:0] direct_angle;
  } in_item_t;

  typedef struct packed {
    logic       servo_write;
    logic [7:0] servo_angle;
    logic       advance_accepted;
    logic       cycle_done;
    logic [1:0] fault_status;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  full_angle;
    logic [7:0]  half_angle;
    logic [7:0]  retract_angle_deg;
    logic [15:0] settle_ms;
    logic        ignore_switch_error;
    logic        has_switch;
    logic [7:0]  unit_length;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  position;
    logic [1:0]  seen_position;
    logic [7:0]  remaining_length;
    logic [1:0]  motion_phase;
    logic [15:0] settle_elapsed;
  } state_t;

  function automatic logic [7:0] angle_of(logic [1:0] pos, cfg_t cfg);
    logic [7:0] a;
    if (pos == POS_FULL) begin
      a = cfg.full_angle;
    end else if (pos == POS_HALF) begin
      a = cfg.half_angle;
    end else begin
      a = cfg.retract_angle_deg;
    end
    return a;
  endfunction

  function automatic logic [1:0] fault_of(logic sw_open, cfg_t cfg);
    logic [1:0] f;
    if (!cfg.has_switch) begin
      f = FLT_NO_LINE;
    end else if (!sw_open) begin
      f = FLT_OK;
    end else if (cfg.ignore_switch_error) begin
      f = FLT_IGNORED;
    end else begin
      f = FLT_ERROR;
    end
    return f;
  endfunction

endpackage

// ===== src/stf_cfg_regs.sv =====
// Configuration register file of the servo tape feeder sequencer.
// Depends on stf_pkg for the register indexes and the cfg_t layout.
module stf_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [stf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output stf_pkg::cfg_t                   cfg
);

  stf_pkg::cfg_t cfg_r;
  stf_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        stf_pkg::REG_FULL_ANGLE:    cfg_nxt.full_angle          = cfg_wdata[7:0];
        stf_pkg::REG_HALF_ANGLE:    cfg_nxt.half_angle          = cfg_wdata[7:0];
        stf_pkg::REG_RETRACT_ANGLE: cfg_nxt.retract_angle_deg   = cfg_wdata[7:0];
        stf_pkg::REG_SETTLE_MS:     cfg_nxt.settle_ms           = cfg_wdata[15:0];
        stf_pkg::REG_IGNORE_SW_ERR: cfg_nxt.ignore_switch_error = cfg_wdata[0];
        stf_pkg::REG_HAS_SWITCH:    cfg_nxt.has_switch          = cfg_wdata[0];
        stf_pkg::REG_UNIT_LENGTH:   cfg_nxt.unit_length         = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_angle          <= 8'd90;
      cfg_r.half_angle          <= 8'd60;
      cfg_r.retract_angle_deg   <= 8'd0;
      cfg_r.settle_ms           <= 16'd240;
      cfg_r.ignore_switch_error <= 1'b0;
      cfg_r.has_switch          <= 1'b1;
      cfg_r.unit_length         <= 8'd4;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/stf_step.sv =====
// Combinational step logic: one request against the current feeder state.
// Depends on stf_pkg for codes, structs and the angle and fault helpers.
module stf_step (
  input  stf_pkg::cfg_t     cfg,
  input  stf_pkg::state_t   state,
  input  stf_pkg::in_item_t item,
  output stf_pkg::state_t   state_nxt,
  output stf_pkg::out_item_t result
);

  logic [1:0] fault;
  logic [7:0] half_len;
  logic       settled;

  assign fault    = stf_pkg::fault_of(item.switch_open, cfg);
  assign half_len = {1'b0, cfg.unit_length[7:1]};

  always_comb begin
    state_nxt               = state;
    result.servo_write      = 1'b0;
    result.servo_angle      = 8'd0;
    result.advance_accepted = 1'b0;
    result.cycle_done       = 1'b0;
    result.fault_status     = fault;
    settled                 = 1'b0;

    case (item.action)
      stf_pkg::ACT_TICK: begin
        // Restart the settle timer on a newly noticed position, else count up
        if (state.seen_position != state.position) begin
          state_nxt.seen_position  = state.position;
          state_nxt.settle_elapsed = 16'd0;
        end else if (state.settle_elapsed != stf_pkg::SETTLE_MAX) begin
          state_nxt.settle_elapsed = state.settle_elapsed + 16'd1;
        end
        settled = (state_nxt.settle_elapsed >= cfg.settle_ms);
        if (settled) begin
          if (state.motion_phase == stf_pkg::PH_COMPLETED) begin
            state_nxt.motion_phase = stf_pkg::PH_IDLE;
            result.cycle_done      = 1'b1;
          end
          if (state.remaining_length != 8'd0) begin
            case (state.position)
              stf_pkg::POS_RETRACT: begin
                if (state.remaining_length >= cfg.unit_length) begin
                  state_nxt.position         = stf_pkg::POS_FULL;
                  state_nxt.motion_phase     = stf_pkg::PH_MOVING;
                  state_nxt.remaining_length = state.remaining_length - cfg.unit_length;
                  result.servo_write         = 1'b1;
                  result.servo_angle         = cfg.full_angle;
                end else if (state.remaining_length >= half_len) begin
                  state_nxt.position         = stf_pkg::POS_HALF;
                  state_nxt.motion_phase     = stf_pkg::PH_MOVING;
                  state_nxt.remaining_length = state.remaining_length - half_len;
                  result.servo_write         = 1'b1;
                  result.servo_angle         = cfg.half_angle;
                end
              end
              stf_pkg::POS_HALF: begin
                if (state.remaining_length >= half_len) begin
                  state_nxt.position         = stf_pkg::POS_FULL;
                  state_nxt.motion_phase     = stf_pkg::PH_MOVING;
                  state_nxt.remaining_length = state.remaining_length - half_len;
                  result.servo_write         = 1'b1;
                  result.servo_angle         = cfg.full_angle;
                end
              end
              stf_pkg::POS_FULL: begin
                state_nxt.position     = stf_pkg::POS_RETRACT;
                state_nxt.motion_phase = stf_pkg::PH_MOVING;
                result.servo_write     = 1'b1;
                result.servo_angle     = cfg.retract_angle_deg;
              end
              default: ;
            endcase
            if (state_nxt.remaining_length == 8'd0) begin
              state_nxt.motion_phase = stf_pkg::PH_COMPLETED;
            end
          end
        end
      end
      stf_pkg::ACT_ADVANCE: begin
        if (!(fault == stf_pkg::FLT_ERROR && !item.override_fault)) begin
          result.advance_accepted = 1'b1;
          // A nonzero request while busy is dropped; anything else loads
          if (!(item.request_length != 8'd0 && state.remaining_length != 8'd0)) begin
            state_nxt.remaining_length = item.request_length;
          end
        end
      end
      stf_pkg::ACT_POST_PICK: begin
        if (state.position == stf_pkg::POS_FULL) begin
          state_nxt.position     = stf_pkg::POS_RETRACT;
          state_nxt.motion_phase = stf_pkg::PH_MOVING;
          result.servo_write     = 1'b1;
          result.servo_angle     = stf_pkg::angle_of(stf_pkg::POS_RETRACT, cfg);
        end
      end
      stf_pkg::ACT_DISABLE: begin
        if (state.position == stf_pkg::POS_HALF) begin
          state_nxt.position     = stf_pkg::POS_FULL;
          state_nxt.motion_phase = stf_pkg::PH_MOVING;
          result.servo_write     = 1'b1;
          result.servo_angle     = stf_pkg::angle_of(stf_pkg::POS_FULL, cfg);
        end
      end
      stf_pkg::ACT_GO_ANGLE: begin
        result.servo_write = 1'b1;
        result.servo_angle = item.direct_angle;
      end
      default: ;
    endcase
  end

endmodule

// ===== src/servo_tape_feeder_sequencer.sv =====
// Top level of the servo tape feeder sequencer.
// Depends on stf_pkg, stf_cfg_regs and stf_step.
//
// Usage:
//   Requests enter on in_valid/in_ready with an in_item_t payload: a
//   millisecond tick, an advance, a post-pick retract, a disable or a direct
//   angle command. Every request yields exactly one result on
//   out_valid/out_ready (servo command, advance acceptance, cycle done flag
//   and switch fault status).
//   An accepted request is held in the input register, then evaluated
//   against the feeder state and stored in the result register, which
//   drives out_data. Throughput: one request per cycle while out_ready
//   holds, as the feeder state updates together with the result register.
//   Stall: when the result register is full and out_ready is low, hold the
//   request in the input register and drop in_ready; both registers fill and
//   the block waits without losing or repeating anything.
//   Reset (rst_n low, synchronous): clear both valid flags, load the default
//   configuration, park the servo at retract with nothing to feed and no
//   position seen yet.
//   Configuration: cfg_we writes cfg_wdata into the register at cfg_index on
//   the same edge; write only while no request is in flight.
module servo_tape_feeder_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  stf_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output stf_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [stf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  stf_pkg::cfg_t      cfg;
  stf_pkg::in_item_t  item_r;
  logic               item_vld_r;
  stf_pkg::state_t    state_r;
  stf_pkg::state_t    state_nxt;
  stf_pkg::out_item_t result_nxt;
  stf_pkg::out_item_t out_r;
  logic               out_vld_r;
  logic               fire;

  stf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  stf_step u_step (
    .cfg       (cfg),
    .state     (state_r),
    .item      (item_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  // The held request moves on whenever the result register is free or draining
  assign fire     = item_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !item_vld_r || fire;

  // Input register: control under reset, payload loaded on accept only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  // Feeder state advances once per evaluated request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.position         <= stf_pkg::POS_RETRACT;
      state_r.seen_position    <= stf_pkg::POS_NONE;
      state_r.remaining_length <= 8'd0;
      state_r.motion_phase     <= stf_pkg::PH_MOVING;
      state_r.settle_elapsed   <= 16'd0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= result_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ===== sim/stf_result_checker.sv =====
// Result checker for the servo tape feeder sequencer testbench.
// Depends on stf_pkg: mirrors the register port, predicts one result per
// accepted request and compares it with what the block delivers.
module stf_result_checker
  import stf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t      regs;
  state_t    feeder;
  out_item_t res;
  out_item_t predicted_results[$];

  // Command a position and restart the motion phase.
  function automatic void drive_servo(logic [1:0] dest);
    feeder.position     = dest;
    feeder.motion_phase = PH_MOVING;
    res.servo_write     = 1'b1;
    case (dest)
      POS_FULL: res.servo_angle = regs.full_angle;
      POS_HALF: res.servo_angle = regs.half_angle;
      default:  res.servo_angle = regs.retract_angle_deg;
    endcase
  endfunction

  // One millisecond tick: run the settle timer, report a finished cycle, step.
  function automatic logic settle_and_step();
    logic [7:0] half_unit;
    logic       done;
    half_unit = regs.unit_length >> 1;
    done = 1'b0;
    if (feeder.seen_position != feeder.position) begin
      feeder.seen_position  = feeder.position;
      feeder.settle_elapsed = '0;
    end else if (feeder.settle_elapsed != SETTLE_MAX) begin
      feeder.settle_elapsed = feeder.settle_elapsed + 16'd1;
    end
    if (feeder.settle_elapsed < regs.settle_ms) return 1'b0;
    if (feeder.motion_phase == PH_COMPLETED) begin
      feeder.motion_phase = PH_IDLE;
      done = 1'b1;
    end
    if (feeder.remaining_length == '0) return done;
    case (feeder.position)
      POS_RETRACT: begin
        if (feeder.remaining_length >= regs.unit_length) begin
          drive_servo(POS_FULL);
          feeder.remaining_length -= regs.unit_length;
        end else if (feeder.remaining_length >= half_unit) begin
          drive_servo(POS_HALF);
          feeder.remaining_length -= half_unit;
        end
      end
      POS_HALF: begin
        if (feeder.remaining_length >= half_unit) begin
          drive_servo(POS_FULL);
          feeder.remaining_length -= half_unit;
        end
      end
      POS_FULL: drive_servo(POS_RETRACT);
      default: ;
    endcase
    if (feeder.remaining_length == '0) feeder.motion_phase = PH_COMPLETED;
    return done;
  endfunction

  function automatic out_item_t next_feeder_result(in_item_t req);
    res = '0;
    if (!regs.has_switch) begin
      res.fault_status = FLT_NO_LINE;
    end else if (!req.switch_open) begin
      res.fault_status = FLT_OK;
    end else if (regs.ignore_switch_error) begin
      res.fault_status = FLT_IGNORED;
    end else begin
      res.fault_status = FLT_ERROR;
    end
    case (req.action)
      ACT_TICK: res.cycle_done = settle_and_step();
      ACT_ADVANCE: begin
        if (res.fault_status != FLT_ERROR || req.override_fault) begin
          res.advance_accepted = 1'b1;
          // load when idle, cancel with zero when busy; otherwise keep
          if ((req.request_length == '0) != (feeder.remaining_length == '0)) begin
            feeder.remaining_length = req.request_length;
          end
        end
      end
      ACT_POST_PICK: if (feeder.position == POS_FULL) drive_servo(POS_RETRACT);
      ACT_DISABLE: if (feeder.position == POS_HALF) drive_servo(POS_FULL);
      ACT_GO_ANGLE: begin
        res.servo_write = 1'b1;
        res.servo_angle = req.direct_angle;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      regs = '{full_angle: 8'd90, half_angle: 8'd60, retract_angle_deg: 8'd0,
               settle_ms: 16'd240, ignore_switch_error: 1'b0, has_switch: 1'b1,
               unit_length: 8'd4};
      feeder = '{position: POS_RETRACT, seen_position: POS_NONE,
                 remaining_length: 8'd0, motion_phase: PH_MOVING, settle_elapsed: 16'd0};
      predicted_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          fail_count++;
          $display("%0t ns: result with no request pending, expected none, actual %h",
                   $time, out_data);
        end else begin
          want = predicted_results.pop_front();
          check_field("servo_write", want.servo_write, out_data.servo_write);
          check_field("servo_angle", want.servo_angle, out_data.servo_angle);
          check_field("advance_accepted", want.advance_accepted, out_data.advance_accepted);
          check_field("cycle_done", want.cycle_done, out_data.cycle_done);
          check_field("fault_status", want.fault_status, out_data.fault_status);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_FULL_ANGLE:    regs.full_angle          = cfg_wdata[7:0];
          REG_HALF_ANGLE:    regs.half_angle          = cfg_wdata[7:0];
          REG_RETRACT_ANGLE: regs.retract_angle_deg   = cfg_wdata[7:0];
          REG_SETTLE_MS:     regs.settle_ms           = cfg_wdata[15:0];
          REG_IGNORE_SW_ERR: regs.ignore_switch_error = cfg_wdata[0];
          REG_HAS_SWITCH:    regs.has_switch          = cfg_wdata[0];
          REG_UNIT_LENGTH:   regs.unit_length         = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predicted_results.push_back(next_feeder_result(in_data));
    end
    pending = predicted_results.size();
  end

endmodule

// ===== sim/servo_tape_feeder_sequencer_tb.sv =====
// Top of the servo tape feeder sequencer testbench: clock, reset, requests,
// register writes and the verdict. Depends on stf_pkg, the block under test
// and stf_result_checker, which predicts and compares every result.
module servo_tape_feeder_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stf_pkg::*;

  localparam int          CLK_HALF         = 4;
  localparam int unsigned CYCLE_LIMIT      = 1_000_000;
  localparam int          RANDOM_PER_PHASE = 170;
  localparam int          PHASES           = 6;
  localparam int          LONG_TICKS       = 150;
  localparam int          IDLE_PERCENT     = 10;

  // Action codes the block must ignore apart from the fault status
  localparam logic [2:0] ACT_SPARE_5 = 3'd5;
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [2:0]            cfg_index = REG_FULL_ANGLE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    fail_count;
  int                    pending;
  bit                    gaps_on   = 1'b0;
  bit                    stalls_on = 1'b0;
  int unsigned           cycles    = 0;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  servo_tape_feeder_sequencer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  stf_result_checker results_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Result side: stall at random about ten percent of the time while stalls are enabled.
  always @(posedge clk) begin
    out_ready <= !stalls_on || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("servo_tape_feeder_sequencer regression: fail");
      $finish;
    end
  end

  function automatic in_item_t request_of(logic [2:0] act, logic [7:0] len, logic ovr,
                                          logic sw, logic [7:0] angle);
    in_item_t r;
    r.action         = act;
    r.request_length = len;
    r.override_fault = ovr;
    r.switch_open    = sw;
    r.direct_angle   = angle;
    return r;
  endfunction

  // Mostly ticks so that advances actually play out; advance lengths stay
  // within three units most of the time, with the odd full-range length,
  // zero-length cancel and unused action code mixed in.
  function automatic in_item_t draw_request(logic [7:0] unit);
    in_item_t    r;
    int unsigned pick;
    int unsigned reach;
    r = request_of(ACT_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                   ($urandom_range(99) < 20), 8'($urandom_range(255)));
    reach = 3 * unit;
    if (reach > 255) reach = 255;
    pick = $urandom_range(99);
    if (pick < 15) begin
      r.action = ACT_ADVANCE;
      pick = $urandom_range(99);
      if (pick < 10) begin
        r.request_length = '0;
      end else if (pick < 80) begin
        r.request_length = 8'($urandom_range(reach, 1));
      end
    end else if (pick < 25) begin
      r.action = ACT_POST_PICK;
    end else if (pick < 32) begin
      r.action = ACT_DISABLE;
    end else if (pick < 40) begin
      r.action = ACT_GO_ANGLE;
    end else if (pick < 45) begin
      r.action = 3'($urandom_range(ACT_SPARE_7, ACT_SPARE_5));
    end
    return r;
  endfunction

  // Present one request and hold it until the block takes it; idle first
  // now and then while gaps are enabled.
  task automatic send_request(input in_item_t r);
    if (gaps_on) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and hold until every predicted result has come back. The
  // count is sampled at the falling edge, clear of the rising-edge updates.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Write every register back to back, then release the write enable.
  task automatic apply_settings(input cfg_t c);
    write_reg(REG_FULL_ANGLE, CFG_DATA_W'(c.full_angle));
    write_reg(REG_HALF_ANGLE, CFG_DATA_W'(c.half_angle));
    write_reg(REG_RETRACT_ANGLE, CFG_DATA_W'(c.retract_angle_deg));
    write_reg(REG_SETTLE_MS, c.settle_ms);
    write_reg(REG_IGNORE_SW_ERR, CFG_DATA_W'(c.ignore_switch_error));
    write_reg(REG_HAS_SWITCH, CFG_DATA_W'(c.has_switch));
    write_reg(REG_UNIT_LENGTH, CFG_DATA_W'(c.unit_length));
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    cfg_t plan [PHASES];
    cfg_t bench;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Settings for each random phase: angle and unit extremes first, then
    // no switch line with odd units, then random picks with short settles.
    plan[0] = '{full_angle: 8'd180, half_angle: 8'd0, retract_angle_deg: 8'd0,
                settle_ms: 16'd0, ignore_switch_error: 1'b0, has_switch: 1'b1,
                unit_length: 8'd2};
    plan[1] = '{full_angle: 8'd0, half_angle: 8'd180, retract_angle_deg: 8'd180,
                settle_ms: 16'd1, ignore_switch_error: 1'b1, has_switch: 1'b1,
                unit_length: 8'd254};
    plan[2] = '{full_angle: 8'd120, half_angle: 8'd45, retract_angle_deg: 8'd10,
                settle_ms: 16'd2, ignore_switch_error: 1'b0, has_switch: 1'b0,
                unit_length: 8'd5};
    plan[3] = '{full_angle: 8'd90, half_angle: 8'd60, retract_angle_deg: 8'd0,
                settle_ms: 16'd3, ignore_switch_error: 1'b1, has_switch: 1'b0,
                unit_length: 8'd3};
    for (int ph = 4; ph < PHASES; ph++) begin
      plan[ph].full_angle          = 8'($urandom_range(180));
      plan[ph].half_angle          = 8'($urandom_range(180));
      plan[ph].retract_angle_deg   = 8'($urandom_range(180));
      plan[ph].settle_ms           = 16'($urandom_range(4));
      plan[ph].ignore_switch_error = 1'($urandom_range(1));
      plan[ph].has_switch          = 1'($urandom_range(1));
      plan[ph].unit_length = ($urandom_range(1) == 1) ? 8'($urandom_range(16, 2))
                                                      : 8'($urandom_range(254, 2));
    end

    // Directed walk with no settle delay: angle extremes, a refused and an
    // overridden advance, a busy advance, stepping through full and half,
    // post pick and disable in and out of position, an unreachable
    // remainder, zero-length cancel, and the unused action codes.
    bench = '{full_angle: 8'd180, half_angle: 8'd90, retract_angle_deg: 8'd0,
              settle_ms: 16'd0, ignore_switch_error: 1'b0, has_switch: 1'b1,
              unit_length: 8'd4};
    apply_settings(bench);
    gaps_on = 1'b1;
    stalls_on <= 1'b1;
    send_request(request_of(ACT_GO_ANGLE, 8'd0, 1'b0, 1'b0, 8'd0));
    send_request(request_of(ACT_GO_ANGLE, 8'd255, 1'b1, 1'b1, 8'd255));
    send_request(request_of(ACT_ADVANCE, 8'd8, 1'b0, 1'b1, 8'd0));
    send_request(request_of(ACT_ADVANCE, 8'd6, 1'b1, 1'b1, 8'd0));
    send_request(request_of(ACT_ADVANCE, 8'd200, 1'b0, 1'b0, 8'd0));
    send_request(request_of(ACT_TICK, 8'd0, 1'b0, 1'b0, 8'd0));
    send_request(request_of(ACT_POST_PICK, 8'd0, 1'b0, 1'b0, 8'd0));
    send_request(request_of(ACT_TICK, 8'd0, 1'b0, 1'b0, 8'd0));
    send_request(request_of(ACT_TICK, 8'd0, 1'b0, 1'b0, 8'd0));
    send_request(request_of(ACT_TICK, 8'd0, 1'b0, 1'b1, 8'd0));
    send_request(request_of(ACT_DISABLE, 8'd0, 1'b0, 1'b0, 8'd0));
    send_request(request_of(ACT_DISABLE, 8'd0, 1'b0, 1'b0, 8'd0));
    send_request(request_of(ACT_POST_PICK, 8'd0, 1'b0, 1'b0, 8'd0));
    send_request(request_of(ACT_POST_PICK, 8'd0, 1'b0, 1'b0, 8'd0));
    send_request(request_of(ACT_ADVANCE, 8'd3, 1'b0, 1'b0, 8'd0));
    send_request(request_of(ACT_TICK, 8'd0, 1'b0, 1'b0, 8'd0));
    send_request(request_of(ACT_TICK, 8'd0, 1'b0, 1'b0, 8'd0));
    send_request(request_of(ACT_TICK, 8'd0, 1'b0, 1'b0, 8'd0));
    send_request(request_of(ACT_ADVANCE, 8'd0, 1'b0, 1'b0, 8'd0));
    send_request(request_of(ACT_ADVANCE, 8'd0, 1'b0, 1'b0, 8'd0));
    send_request(request_of(ACT_SPARE_5, 8'd0, 1'b0, 1'b1, 8'd0));
    send_request(request_of(ACT_SPARE_6, 8'd0, 1'b0, 1'b0, 8'd0));
    send_request(request_of(ACT_SPARE_7, 8'd0, 1'b0, 1'b1, 8'd0));

    // Random phases, each under its own settings written while idle.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      apply_settings(plan[ph]);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // hold the sender once mid-phase until the block has emptied out
        if (ph == 1 && n == RANDOM_PER_PHASE / 2) wait_drained();
        send_request(draw_request(plan[ph].unit_length));
      end
    end

    // Longest settle with no idling on either side: the timer keeps counting
    // far below its threshold, so the pending advance must not step before
    // the zero-length cancel drops it.
    wait_drained();
    gaps_on = 1'b0;
    stalls_on <= 1'b0;
    bench = plan[0];
    bench.settle_ms   = SETTLE_MAX;
    bench.unit_length = 8'd4;
    apply_settings(bench);
    send_request(request_of(ACT_ADVANCE, 8'd4, 1'b0, 1'b0, 8'd0));
    repeat (LONG_TICKS) begin
      send_request(request_of(ACT_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 8'($urandom_range(255))));
    end
    send_request(request_of(ACT_ADVANCE, 8'd0, 1'b0, 1'b0, 8'd0));
    send_request(request_of(ACT_TICK, 8'd0, 1'b0, 1'b0, 8'd0));
    send_request(request_of(ACT_TICK, 8'd0, 1'b0, 1'b0, 8'd0));

    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("servo_tape_feeder_sequencer regression: pass");
    end else begin
      $display("servo_tape_feeder_sequencer regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/stf_pkg.sv
src/stf_cfg_regs.sv
src/stf_step.sv
src/servo_tape_feeder_sequencer.sv
sim/stf_result_checker.sv
sim/servo_tape_feeder_sequencer_tb.sv
